FILE: hw/rtl/mbt_pkg.sv
// ----------------------------------------------------------------------------
// mbt_pkg
// Shared types and constants for the multibit trie exact-match block.
// ----------------------------------------------------------------------------
`default_nettype none

package mbt_pkg;

  localparam int KEY_BITS   = 48;
  localparam int VAL_BITS   = 32;
  localparam int DIGIT_BITS = 6;
  localparam int DIGITS     = KEY_BITS / DIGIT_BITS;
  localparam int LVL_BITS   = $clog2(DIGITS);
  localparam int NODE_POOL  = 1024;
  localparam int NODE_BITS  = $clog2(NODE_POOL);
  localparam int SLOT_BITS  = NODE_BITS + DIGIT_BITS;
  localparam int CNT_BITS   = 7;
  localparam int TOP_BITS   = NODE_BITS + 1;
  localparam int FANOUT     = 64;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NO_SPACE  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK_RD,
    S_WALK_CHK,
    S_ALLOC_RD,
    S_ALLOC_WR,
    S_INC_RD,
    S_INC_WR,
    S_DEL_LEAF,
    S_DEC_RD,
    S_DEC_WR,
    S_PRUNE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 ent_we;
    logic [SLOT_BITS-1:0] ent_addr;
    logic                 ent_wvalid;
    logic [VAL_BITS-1:0]  ent_wdata;
    logic                 fill_we;
    logic [NODE_BITS-1:0] fill_addr;
    logic [CNT_BITS-1:0]  fill_wdata;
    logic                 stk_we;
    logic [NODE_BITS-1:0] stk_addr;
    logic [NODE_BITS-1:0] stk_wdata;
  } mem_req_t;

  typedef struct packed {
    logic                 ent_valid;
    logic [VAL_BITS-1:0]  ent_data;
    logic [CNT_BITS-1:0]  fill;
    logic [NODE_BITS-1:0] stk;
  } mem_rsp_t;

  function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [KEY_BITS-1:0] k,
                                                     input logic [LVL_BITS-1:0] l);
    digit_of = k[DIGIT_BITS*l +: DIGIT_BITS];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mbt_mem.sv
// ----------------------------------------------------------------------------
// mbt_mem
// Entry store, node fill counts and free node stack, one port each,
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mbt_mem import mbt_pkg::*; (
  input  wire logic     clk,
  input  wire mem_req_t req,
  output mem_rsp_t      rsp
);

  logic [VAL_BITS:0]    ent_mem  [NODE_POOL*FANOUT];
  logic [CNT_BITS-1:0]  fill_mem [NODE_POOL];
  logic [NODE_BITS-1:0] stk_mem  [NODE_POOL];

  always_ff @(posedge clk) begin
    if (req.ent_we) begin
      ent_mem[req.ent_addr] <= {req.ent_wvalid, req.ent_wdata};
    end
    if (req.fill_we) begin
      fill_mem[req.fill_addr] <= req.fill_wdata;
    end
    if (req.stk_we) begin
      stk_mem[req.stk_addr] <= req.stk_wdata;
    end
    {rsp.ent_valid, rsp.ent_data} <= ent_mem[req.ent_addr];
    rsp.fill                      <= fill_mem[req.fill_addr];
    rsp.stk                       <= stk_mem[req.stk_addr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/multibit_trie_exact_match.sv
// ----------------------------------------------------------------------------
// multibit_trie_exact_match
// Exact-match map over an eight-level trie of 64-way nodes.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the entry store (busy
// high). A request is taken when start is high and busy is low; one result
// follows, shown for one cycle with done high, and must be taken then. Busy
// stays high until the result has been shown, so one request is worked at a
// time. Lookup reads the entry store once per trie level; insert also takes
// a node from the free stack for each missing level and counts each new slot
// in its parent's fill; delete clears the leaf and prunes nodes left empty.
// The single-port entry store, read once per level, sets the rate.
`default_nettype none

module multibit_trie_exact_match import mbt_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          command,
  input  wire logic [KEY_BITS-1:0] key,
  input  wire logic [VAL_BITS-1:0] value,
  output logic                     done,
  output logic [1:0]               status,
  output logic                     found,
  output logic [VAL_BITS-1:0]      result_value
);

  localparam logic [LVL_BITS-1:0] LEAF_LVL = LVL_BITS'(DIGITS - 1);

  state_t               state, state_next;
  logic [SLOT_BITS-1:0] clr_cnt, clr_cnt_next;
  logic [1:0]           cmd, cmd_next;
  logic [KEY_BITS-1:0]  key_r, key_r_next;
  logic [VAL_BITS-1:0]  val_r, val_r_next;
  logic [NODE_BITS-1:0] node, node_next;
  logic [LVL_BITS-1:0]  lvl, lvl_next;
  logic [NODE_BITS-1:0] path [DIGITS];
  logic [NODE_BITS-1:0] path_next [DIGITS];
  logic [TOP_BITS-1:0]  top, top_next;
  logic [NODE_BITS-1:0] aux, aux_next;
  logic                 inc_last, inc_last_next;
  logic [CNT_BITS-1:0]  cur_cnt, cur_cnt_next;
  status_t              st, st_next;
  logic                 fnd, fnd_next;
  logic [VAL_BITS-1:0]  res, res_next;

  mem_req_t req;
  mem_rsp_t rsp;

  logic [TOP_BITS-1:0]  top_dec;
  logic [LVL_BITS-1:0]  lvl_up;
  logic [LVL_BITS-1:0]  lvl_dn;
  logic [LVL_BITS-1:0]  need;
  logic [CNT_BITS-1:0]  cnt_dec;

  mbt_mem u_mem (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  assign top_dec = top - TOP_BITS'(1);
  assign lvl_up  = lvl + LVL_BITS'(1);
  assign lvl_dn  = lvl - LVL_BITS'(1);
  assign need    = LEAF_LVL - lvl;
  assign cnt_dec = (rsp.fill != '0) ? rsp.fill - CNT_BITS'(1) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      top     <= TOP_BITS'(NODE_POOL - 1);
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      top     <= top_next;
    end
    cmd      <= cmd_next;
    key_r    <= key_r_next;
    val_r    <= val_r_next;
    node     <= node_next;
    lvl      <= lvl_next;
    path     <= path_next;
    aux      <= aux_next;
    inc_last <= inc_last_next;
    cur_cnt  <= cur_cnt_next;
    st       <= st_next;
    fnd      <= fnd_next;
    res      <= res_next;
  end

  always_comb begin
    state_next    = state;
    clr_cnt_next  = clr_cnt;
    cmd_next      = cmd;
    key_r_next    = key_r;
    val_r_next    = val_r;
    node_next     = node;
    lvl_next      = lvl;
    path_next     = path;
    top_next      = top;
    aux_next      = aux;
    inc_last_next = inc_last;
    cur_cnt_next  = cur_cnt;
    st_next       = st;
    fnd_next      = fnd;
    res_next      = res;
    req           = '0;
    busy          = 1'b1;
    done          = 1'b0;

    unique case (state)
      S_CLEAR: begin
        req.ent_we   = 1'b1;
        req.ent_addr = clr_cnt;
        if (clr_cnt < SLOT_BITS'(NODE_POOL)) begin
          req.fill_we   = 1'b1;
          req.fill_addr = clr_cnt[NODE_BITS-1:0];
          req.stk_we    = 1'b1;
          req.stk_addr  = clr_cnt[NODE_BITS-1:0];
          req.stk_wdata = clr_cnt[NODE_BITS-1:0] + NODE_BITS'(1);
        end
        clr_cnt_next = clr_cnt + SLOT_BITS'(1);
        if (clr_cnt == '1) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_next   = command;
          key_r_next = key;
          val_r_next = value;
          node_next  = '0;
          lvl_next   = '0;
          st_next    = ST_NOT_FOUND;
          fnd_next   = 1'b0;
          res_next   = '0;
          if (command == CMD_INSERT || command == CMD_DELETE || command == CMD_LOOKUP) begin
            state_next = S_WALK_RD;
          end else begin
            state_next = S_DONE;
          end
        end
      end

      S_WALK_RD: begin
        req.ent_addr    = {node, digit_of(key_r, lvl)};
        path_next[lvl]  = node;
        state_next      = S_WALK_CHK;
      end

      S_WALK_CHK: begin
        if (lvl == LEAF_LVL) begin
          if (cmd == CMD_INSERT) begin
            req.ent_we     = 1'b1;
            req.ent_addr   = {node, digit_of(key_r, lvl)};
            req.ent_wvalid = 1'b1;
            req.ent_wdata  = val_r;
            st_next        = ST_OK;
            if (!rsp.ent_valid) begin
              aux_next      = node;
              inc_last_next = 1'b1;
              state_next    = S_INC_RD;
            end else begin
              state_next = S_DONE;
            end
          end else if (!rsp.ent_valid) begin
            state_next = S_DONE;
          end else if (cmd == CMD_DELETE) begin
            state_next = S_DEL_LEAF;
          end else begin
            st_next    = ST_OK;
            fnd_next   = 1'b1;
            res_next   = rsp.ent_data;
            state_next = S_DONE;
          end
        end else if (rsp.ent_valid) begin
          node_next  = rsp.ent_data[NODE_BITS-1:0];
          lvl_next   = lvl_up;
          state_next = S_WALK_RD;
        end else if (cmd == CMD_INSERT) begin
          if (TOP_BITS'(need) > top) begin
            st_next    = ST_NO_SPACE;
            state_next = S_DONE;
          end else begin
            state_next = S_ALLOC_RD;
          end
        end else begin
          state_next = S_DONE;
        end
      end

      S_ALLOC_RD: begin
        top_next     = top_dec;
        req.stk_addr = top_dec[NODE_BITS-1:0];
        state_next   = S_ALLOC_WR;
      end

      S_ALLOC_WR: begin
        req.ent_we     = 1'b1;
        req.ent_addr   = {node, digit_of(key_r, lvl)};
        req.ent_wvalid = 1'b1;
        req.ent_wdata  = VAL_BITS'(rsp.stk);
        req.fill_we    = 1'b1;
        req.fill_addr  = rsp.stk;
        aux_next       = node;
        inc_last_next  = 1'b0;
        node_next      = rsp.stk;
        lvl_next       = lvl_up;
        state_next     = S_INC_RD;
      end

      S_INC_RD: begin
        req.fill_addr = aux;
        state_next    = S_INC_WR;
      end

      S_INC_WR: begin
        req.fill_we    = 1'b1;
        req.fill_addr  = aux;
        req.fill_wdata = (rsp.fill < CNT_BITS'(FANOUT)) ? rsp.fill + CNT_BITS'(1) : rsp.fill;
        if (inc_last) begin
          state_next = S_DONE;
        end else if (lvl == LEAF_LVL) begin
          state_next = S_WALK_RD;
        end else begin
          state_next = S_ALLOC_RD;
        end
      end

      S_DEL_LEAF: begin
        req.ent_we   = 1'b1;
        req.ent_addr = {node, digit_of(key_r, lvl)};
        aux_next     = node;
        st_next      = ST_OK;
        fnd_next     = 1'b1;
        state_next   = S_DEC_RD;
      end

      S_DEC_RD: begin
        req.fill_addr = aux;
        state_next    = S_DEC_WR;
      end

      S_DEC_WR: begin
        req.fill_we    = 1'b1;
        req.fill_addr  = aux;
        req.fill_wdata = cnt_dec;
        cur_cnt_next   = cnt_dec;
        state_next     = S_PRUNE;
      end

      S_PRUNE: begin
        if (lvl == '0 || cur_cnt != '0 || path[lvl] == '0) begin
          state_next = S_DONE;
        end else begin
          if (!top[TOP_BITS-1]) begin
            req.stk_we    = 1'b1;
            req.stk_addr  = top[NODE_BITS-1:0];
            req.stk_wdata = path[lvl];
            top_next      = top + TOP_BITS'(1);
          end
          req.ent_we   = 1'b1;
          req.ent_addr = {path[lvl_dn], digit_of(key_r, lvl_dn)};
          aux_next     = path[lvl_dn];
          lvl_next     = lvl_dn;
          state_next   = S_DEC_RD;
        end
      end

      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign status       = st;
  assign found        = fnd;
  assign result_value = res;

endmodule

`default_nettype wire

FILE: tb/tb_multibit_trie_exact_match.sv
// ----------------------------------------------------------------------------
// tb_multibit_trie_exact_match
// Self-checking bench for the multibit trie exact-match block: directed edge
// cases, node pool exhaustion and randomized insert/delete/lookup traffic,
// each result compared against a trie predictor kept inside the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_multibit_trie_exact_match;
  import mbt_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int LEAF_LVL = DIGITS - 1;

  typedef struct {
    status_t            status;
    logic               found;
    logic [VAL_BITS-1:0] result_value;
  } lookup_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [1:0]          command = CMD_LOOKUP;
  logic [KEY_BITS-1:0] key = '0;
  logic [VAL_BITS-1:0] value = '0;
  logic                busy;
  logic                done;
  logic [1:0]          status;
  logic                found;
  logic [VAL_BITS-1:0] result_value;

  bit                  slot_valid [NODE_POOL*FANOUT];
  logic [VAL_BITS-1:0] slot_payload [NODE_POOL*FANOUT];
  int                  fill_count [NODE_POOL];
  int                  free_stack [NODE_POOL];
  int                  free_top;

  lookup_result_t      pending_results [$];
  logic [KEY_BITS-1:0] stored_keys [$];
  int                  mismatches = 0;
  int                  send_idle_pct = 0;

  multibit_trie_exact_match DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .key(key), .value(value),
    .done(done), .status(status), .found(found), .result_value(result_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("multibit_trie_exact_match test failed");
    $finish;
  end

  function automatic int digit_at(logic [KEY_BITS-1:0] k, int d);
    return int'(k[DIGIT_BITS*d +: DIGIT_BITS]);
  endfunction

  function automatic int slot_at(int node, int dig);
    return node * FANOUT + dig;
  endfunction

  function automatic int child_at(int s);
    return (slot_payload[s] < NODE_POOL) ? int'(slot_payload[s]) : 0;
  endfunction

  function automatic void trie_clear();
    for (int i = 0; i < NODE_POOL*FANOUT; i++) begin
      slot_valid[i] = 1'b0;
      slot_payload[i] = '0;
    end
    for (int i = 0; i < NODE_POOL; i++) begin
      fill_count[i] = 0;
      free_stack[i] = (i + 1 < NODE_POOL) ? i + 1 : 0;
    end
    free_top = NODE_POOL - 1;
  endfunction

  function automatic status_t trie_insert(logic [KEY_BITS-1:0] k, logic [VAL_BITS-1:0] v);
    int node;
    int lvl;
    int s;
    int n;
    node = 0;
    for (lvl = 0; lvl < LEAF_LVL; lvl++) begin
      s = slot_at(node, digit_at(k, lvl));
      if (!slot_valid[s]) break;
      node = child_at(s);
    end
    if (LEAF_LVL - lvl > free_top) return ST_NO_SPACE;
    for (; lvl < LEAF_LVL; lvl++) begin
      free_top--;
      n = free_stack[free_top];
      fill_count[n] = 0;
      s = slot_at(node, digit_at(k, lvl));
      slot_valid[s] = 1'b1;
      slot_payload[s] = VAL_BITS'(n);
      if (fill_count[node] < FANOUT) fill_count[node]++;
      node = n;
    end
    s = slot_at(node, digit_at(k, LEAF_LVL));
    if (!slot_valid[s] && fill_count[node] < FANOUT) fill_count[node]++;
    slot_valid[s] = 1'b1;
    slot_payload[s] = v;
    return ST_OK;
  endfunction

  function automatic bit trie_find(logic [KEY_BITS-1:0] k, ref int path[DIGITS], ref int leaf);
    int node;
    int s;
    node = 0;
    for (int lvl = 0; lvl < LEAF_LVL; lvl++) begin
      path[lvl] = node;
      s = slot_at(node, digit_at(k, lvl));
      if (!slot_valid[s]) return 1'b0;
      node = child_at(s);
    end
    path[LEAF_LVL] = node;
    leaf = slot_at(node, digit_at(k, LEAF_LVL));
    return slot_valid[leaf];
  endfunction

  function automatic bit trie_delete(logic [KEY_BITS-1:0] k);
    int path[DIGITS];
    int leaf;
    int n;
    int parent;
    int s;
    leaf = 0;
    if (!trie_find(k, path, leaf)) return 1'b0;
    slot_valid[leaf] = 1'b0;
    slot_payload[leaf] = '0;
    if (fill_count[path[LEAF_LVL]] > 0) fill_count[path[LEAF_LVL]]--;
    for (int lvl = LEAF_LVL; lvl >= 1; lvl--) begin
      n = path[lvl];
      parent = path[lvl-1];
      if (fill_count[n] != 0 || n == 0) break;
      if (free_top < NODE_POOL) begin
        free_stack[free_top] = n;
        free_top++;
      end
      s = slot_at(parent, digit_at(k, lvl-1));
      slot_valid[s] = 1'b0;
      slot_payload[s] = '0;
      if (fill_count[parent] > 0) fill_count[parent]--;
    end
    return 1'b1;
  endfunction

  function automatic lookup_result_t trie_apply(logic [1:0] cmd, logic [KEY_BITS-1:0] k,
                                               logic [VAL_BITS-1:0] v);
    lookup_result_t r;
    int path[DIGITS];
    int leaf;
    r.status = ST_NOT_FOUND;
    r.found = 1'b0;
    r.result_value = '0;
    leaf = 0;
    case (cmd)
      CMD_INSERT: begin
        r.status = trie_insert(k, v);
      end
      CMD_DELETE: begin
        if (trie_delete(k)) begin
          r.status = ST_OK;
          r.found = 1'b1;
        end
      end
      CMD_LOOKUP: begin
        if (trie_find(k, path, leaf)) begin
          r.status = ST_OK;
          r.found = 1'b1;
          r.result_value = slot_payload[leaf];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(logic [1:0] cmd, logic [KEY_BITS-1:0] k,
                              logic [VAL_BITS-1:0] v);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
      repeat ($urandom_range(1, 6)) @(posedge clk);
    @(posedge clk);
    start <= 1'b1;
    command <= cmd;
    key <= k;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(trie_apply(cmd, k, v));
    if (cmd == CMD_INSERT) stored_keys.push_back(k);
    start <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with no request outstanding");
      end else begin
        exp_r = pending_results.pop_front();
        if (status !== exp_r.status || found !== exp_r.found ||
            result_value !== exp_r.result_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: expected status=%0d found=%0b value=%h, got %0d %0b %h",
                     exp_r.status, exp_r.found, exp_r.result_value,
                     status, found, result_value);
        end
      end
    end
  end

  task automatic test_directed();
    logic [KEY_BITS-1:0] ones;
    logic [KEY_BITS-1:0] sib;
    ones = '1;
    sib = ones ^ (KEY_BITS'(6'h3f) << (DIGIT_BITS*LEAF_LVL));
    send_request(CMD_LOOKUP, '0, '0);
    send_request(CMD_DELETE, '0, '0);
    send_request(CMD_INSERT, '0, '0);
    send_request(CMD_INSERT, ones, '1);
    send_request(CMD_LOOKUP, '0, '1);
    send_request(CMD_LOOKUP, ones, '0);
    send_request(CMD_INSERT, ones, 32'h5a5a_a5a5);
    send_request(CMD_LOOKUP, ones, '0);
    send_request(CMD_INSERT, sib, 32'h1234_5678);
    send_request(CMD_LOOKUP, sib, '0);
    send_request(CMD_DELETE, ones, '0);
    send_request(CMD_LOOKUP, ones, '0);
    send_request(CMD_LOOKUP, sib, '0);
    send_request(CMD_DELETE, ones, '0);
    send_request(CMD_UNUSED, sib, '1);
    send_request(CMD_LOOKUP, sib, '0);
    send_request(CMD_DELETE, sib, '0);
    send_request(CMD_DELETE, '0, '0);
    send_request(CMD_LOOKUP, '0, '0);
    send_request(CMD_LOOKUP, 48'h0000_0000_0040, '0);
    drain_results();
    stored_keys.delete();
  endtask

  task automatic test_pool_exhaustion();
    logic [KEY_BITS-1:0] k;
    int i;
    i = 0;
    while (free_top >= LEAF_LVL - 1) begin
      k = KEY_BITS'({$urandom, $urandom});
      k[DIGIT_BITS*2-1:0] = 12'(i);
      send_request(CMD_INSERT, k, $urandom);
      i++;
    end
    k = stored_keys[0];
    k[DIGIT_BITS*LEAF_LVL +: DIGIT_BITS] ^= 6'h15;
    send_request(CMD_INSERT, k, $urandom);
    k = stored_keys[1];
    k[DIGIT_BITS*1 +: DIGIT_BITS] ^= 6'h2a;
    send_request(CMD_INSERT, k, $urandom);
    send_request(CMD_LOOKUP, k, '0);
    drain_results();
    while (stored_keys.size() != 0) send_request(CMD_DELETE, stored_keys.pop_front(), '0);
    send_request(CMD_INSERT, {KEY_BITS{1'b1}}, $urandom);
    drain_results();
  endtask

  task automatic test_random_traffic(int idle_pct, int count);
    int pick;
    logic [KEY_BITS-1:0] k;
    logic [1:0] cmd;
    send_idle_pct = idle_pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      cmd = (pick < 40) ? CMD_INSERT : (pick < 65) ? CMD_DELETE :
            (pick < 97) ? CMD_LOOKUP : CMD_UNUSED;
      k = KEY_BITS'({$urandom, $urandom});
      pick = $urandom_range(99);
      if (pick < 55 && stored_keys.size() != 0) begin
        k = stored_keys[$urandom_range(stored_keys.size()-1)];
        if ($urandom_range(3) == 0) k[DIGIT_BITS*$urandom_range(LEAF_LVL) +: 2] ^= 2'($urandom);
      end else if (pick < 80) begin
        for (int d = 0; d < DIGITS; d++)
          k[DIGIT_BITS*d +: DIGIT_BITS] = 6'($urandom_range(2));
      end
      send_request(cmd, k, $urandom);
    end
    drain_results();
    send_idle_pct = 0;
  endtask

  initial begin
    trie_clear();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_pool_exhaustion();
    test_random_traffic(13, 20);
    test_random_traffic(67, 20);
    test_random_traffic(0, 20);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("multibit_trie_exact_match test passed");
    else
      $display("multibit_trie_exact_match test failed");
    $finish;
  end

endmodule

`default_nettype wire
